@@ sv/wmf_pkg.sv @@
// wmf_pkg: shared types and constants of the window median filter
// no dependencies

package wmf_pkg;

   localparam int PIX_PORT_BITS  = 16;
   localparam int W_REG_BITS     = 11;
   localparam int H_REG_BITS     = 13;
   localparam int R_REG_BITS     = 2;
   localparam int CSR_DATA_BITS  = 13;
   localparam int CSR_INDEX_BITS = 2;
   localparam int HEIGHT_MAX     = 4096;
   localparam int CNT_BITS       = 23;
   localparam int ROW_BITS       = 14;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT  = 2'd1,
      CSR_WINDOW_RADIUS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic frame_end;
   } ctl_type;

endpackage

@@ sv/wmf_if.sv @@
// wmf_req_if / wmf_rsp_if: item channels of the window median filter
// depends on wmf_pkg

interface wmf_req_if;
   import wmf_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [PIX_PORT_BITS-1:0] pixel_value;
   logic                     pad_item;
   modport source (output valid, output pixel_value, output pad_item, input ready);
   modport sink (input valid, input pixel_value, input pad_item, output ready);
endinterface

interface wmf_rsp_if;
   import wmf_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [PIX_PORT_BITS-1:0] median_value;
   logic                     frame_end;
   modport source (output valid, output median_value, output frame_end, input ready);
   modport sink (input valid, input median_value, input frame_end, output ready);
endinterface

@@ sv/window_median_filter.sv @@
// window_median_filter: streaming 2d median filter with replicated borders
// depends on wmf_pkg, wmf_if, wmf_ram, wmf_median
//
// req_ch carries one pixel per item in raster order; after the last pixel the
// source sends R*width+R pad items. a pad item before the frame is complete
// is a bubble and gives nothing. rsp_ch gives the median of the clamped
// window for output pixel k on the item that is number k+R*width+R of the
// frame, frame_end marks the last one. csr_* writes width, height and radius;
// the user must write only while the block is idle, the block does not
// enforce it. req_ch.ready stays low after a write while the derived frame
// values settle. throughput is one item per cycle unless stalled; an item's
// result passes memory read, column build, window build, compare, rank count,
// output register. row history sits in 2*MAX_RADIUS+1 row banks, one read
// and one write per cycle each. the pipeline moves as one: while the output
// register holds a result the receiver does not take, req_ch.ready is low.
// reset clears counters and loads the default registers; the row banks are
// not cleared.

module window_median_filter #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_RADIUS = 2,
   parameter int PIXEL_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   wmf_req_if.sink                              req_ch,
   wmf_rsp_if.source                            rsp_ch,
   input  logic                                 csr_write_enable,
   input  logic [wmf_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [wmf_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import wmf_pkg::*;

   localparam int NB   = 2 * MAX_RADIUS + 1;
   localparam int NW   = NB * NB;
   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int RW   = $clog2(MAX_RADIUS + 1);
   localparam int BW   = $clog2(NB);
   localparam int NPW  = WW + H_REG_BITS;
   localparam int DW   = WW + RW + 1;
   localparam int EW   = ((NPW > DW) ? NPW : DW) + 1;
   localparam int RST_W = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
   localparam int RST_R = (1 > MAX_RADIUS) ? MAX_RADIUS : 1;
   localparam int RST_D = RST_R * RST_W + RST_R;

   // configuration
   logic [W_REG_BITS-1:0] w_raw_ff;
   logic [H_REG_BITS-1:0] h_raw_ff;
   logic [R_REG_BITS-1:0] r_raw_ff;
   logic [WW-1:0]         w_eff;
   logic [H_REG_BITS-1:0] h_eff;
   logic [RW-1:0]         r_eff;
   logic [WW-1:0]         w_ff;
   logic [H_REG_BITS-1:0] h_ff;
   logic [RW-1:0]         r_ff;
   logic [NPW-1:0]        npix_ff;
   logic [DW-1:0]         delay_ff;
   logic [EW-1:0]         endc_ff, endm1_ff;
   logic [NPW-1:0]        npix_in;
   logic [DW-1:0]         delay_in;
   logic [1:0]            settle_ff;

   // input side counters
   logic [CNT_BITS-1:0] t_ff, t_c;
   logic [XW-1:0]       rc_ff, rc_c, ox_ff, ox_c;
   logic [ROW_BITS-1:0] ry_ff, ry_c;
   logic [BW-1:0]       bank_ff, bank_c, hb_ff;
   logic                restart, pixph, ov, fe, go, en;
   logic [PIXEL_BITS-1:0] pix;

   // column stage
   logic                  b_valid_ff, b_pixph_ff, b_ov_ff, b_fe_ff;
   logic [PIXEL_BITS-1:0] b_pix_ff;
   logic [ROW_BITS-1:0]   b_ry_ff;
   logic [BW-1:0]         b_bank_ff, b_hb_ff;
   logic [XW-1:0]         b_ox_ff;
   logic [PIXEL_BITS-1:0] rd_data [NB];
   logic [PIXEL_BITS-1:0] vec_in [NB];
   logic [PIXEL_BITS-1:0] cols_ff [NB][NB];

   // window stage
   logic          c_valid_ff, c_fe_ff;
   logic [XW-1:0] c_ox_ff;
   logic [BW-1:0] col_idx [NB];
   logic [PIXEL_BITS-1:0] win_in [NW];
   ctl_type       c_ctl, m_ctl;
   logic [PIXEL_BITS-1:0] m_value;

   logic                     rsp_valid_ff, rsp_fe_ff;
   logic [PIX_PORT_BITS-1:0] rsp_median_ff;

   always_comb begin
      if (32'(w_raw_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else if (w_raw_ff == '0) begin
         w_eff = WW'(1);
      end else begin
         w_eff = WW'(w_raw_ff);
      end
      if (32'(h_raw_ff) > 32'(HEIGHT_MAX)) begin
         h_eff = H_REG_BITS'(HEIGHT_MAX);
      end else if (h_raw_ff == '0) begin
         h_eff = H_REG_BITS'(1);
      end else begin
         h_eff = h_raw_ff;
      end
      if (32'(r_raw_ff) > 32'(MAX_RADIUS)) begin
         r_eff = RW'(MAX_RADIUS);
      end else begin
         r_eff = RW'(r_raw_ff);
      end
      npix_in  = NPW'(w_eff) * NPW'(h_eff);
      delay_in = DW'(r_eff) * DW'(w_eff) + DW'(r_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_raw_ff  <= W_REG_BITS'(1024);
         h_raw_ff  <= H_REG_BITS'(1);
         r_raw_ff  <= R_REG_BITS'(1);
         w_ff      <= WW'(RST_W);
         h_ff      <= H_REG_BITS'(1);
         r_ff      <= RW'(RST_R);
         npix_ff   <= NPW'(RST_W);
         delay_ff  <= DW'(RST_D);
         endc_ff   <= EW'(RST_W + RST_D);
         endm1_ff  <= EW'(RST_W + RST_D - 1);
         settle_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FRAME_WIDTH: begin
                  w_raw_ff <= csr_data[W_REG_BITS-1:0];
               end
               CSR_FRAME_HEIGHT: begin
                  h_raw_ff <= csr_data[H_REG_BITS-1:0];
               end
               CSR_WINDOW_RADIUS: begin
                  r_raw_ff <= csr_data[R_REG_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
         // derived values follow a write via npix_ff and delay_ff into endc_ff and endm1_ff
         if (csr_write_enable) begin
            settle_ff <= 2'd2;
         end else if (settle_ff != '0) begin
            settle_ff <= settle_ff - 2'd1;
         end
         w_ff     <= w_eff;
         h_ff     <= h_eff;
         r_ff     <= r_eff;
         npix_ff  <= npix_in;
         delay_ff <= delay_in;
         endc_ff  <= EW'(npix_ff) + EW'(delay_ff);
         endm1_ff <= EW'(npix_ff) + EW'(delay_ff) - EW'(1);
      end
   end

   assign en = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en && (settle_ff == '0);
   assign pix = PIXEL_BITS'(req_ch.pixel_value);

   always_comb begin
      restart = 32'(t_ff) >= 32'(endc_ff);
      t_c     = restart ? '0 : t_ff;
      rc_c    = restart ? '0 : rc_ff;
      ry_c    = restart ? '0 : ry_ff;
      bank_c  = restart ? '0 : bank_ff;
      ox_c    = restart ? '0 : ox_ff;
      pixph   = 32'(t_c) < 32'(npix_ff);
      ov      = 32'(t_c) >= 32'(delay_ff);
      fe      = 32'(t_c) == 32'(endm1_ff);
      go      = req_ch.valid && req_ch.ready && (!pixph || !req_ch.pad_item);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff    <= '0;
         rc_ff   <= '0;
         ry_ff   <= '0;
         bank_ff <= '0;
         ox_ff   <= '0;
      end else if (go) begin
         if (fe) begin
            t_ff    <= '0;
            rc_ff   <= '0;
            ry_ff   <= '0;
            bank_ff <= '0;
            ox_ff   <= '0;
         end else begin
            t_ff <= t_c + CNT_BITS'(1);
            if (32'(rc_c) + 1 == 32'(w_ff)) begin
               rc_ff   <= '0;
               ry_ff   <= ry_c + ROW_BITS'(1);
               bank_ff <= (32'(bank_c) == NB - 1) ? '0 : bank_c + BW'(1);
            end else begin
               rc_ff   <= rc_c + XW'(1);
               ry_ff   <= ry_c;
               bank_ff <= bank_c;
            end
            if (ov) begin
               ox_ff <= (32'(ox_c) + 1 == 32'(w_ff)) ? '0 : ox_c + XW'(1);
            end else begin
               ox_ff <= ox_c;
            end
         end
      end
   end

   // bank of the last frame row, used for rows clamped at the bottom
   always_ff @(posedge clock) begin
      if (go && (32'(ry_c) + 1 == 32'(h_ff))) begin
         hb_ff <= bank_c;
      end
   end

   for (genvar b = 0; b < NB; b++) begin : g_bank
      wmf_ram #(
         .WIDTH (PIXEL_BITS),
         .DEPTH (MAX_WIDTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (go && pixph && (32'(bank_c) == b)),
         .wr_addr (rc_c),
         .wr_data (pix),
         .rd_en   (go),
         .rd_addr (rc_c),
         .rd_data (rd_data[b])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= go;
         c_valid_ff <= b_valid_ff && b_ov_ff;
      end
      if (en) begin
         b_pix_ff   <= pix;
         b_pixph_ff <= pixph;
         b_ov_ff    <= ov;
         b_fe_ff    <= fe;
         b_ry_ff    <= ry_c;
         b_bank_ff  <= bank_c;
         b_hb_ff    <= hb_ff;
         b_ox_ff    <= ox_c;
         c_ox_ff    <= b_ox_ff;
         c_fe_ff    <= b_fe_ff;
      end
      if (en && b_valid_ff) begin
         cols_ff[0] <= vec_in;
         for (int k = 1; k < NB; k++) begin
            cols_ff[k] <= cols_ff[k-1];
         end
      end
   end

   // column vector: rows ry-2r .. ry, clamped into the frame
   always_comb begin
      int   m;
      int   bk;
      logic fwd;
      for (int j = 0; j < NB; j++) begin
         m  = int'(r_ff) - (j - MAX_RADIUS);
         bk = 0;
         fwd = 1'b0;
         vec_in[j] = '0;
         if (m >= 0 && m <= 2 * int'(r_ff)) begin
            if (int'(b_ry_ff) < m) begin
               bk  = 0;
               fwd = (b_ry_ff == '0) && b_pixph_ff;
            end else if (int'(b_ry_ff) - m > int'(h_ff) - 1) begin
               bk  = int'(b_hb_ff);
            end else begin
               bk = int'(b_bank_ff) - m;
               if (bk < 0) begin
                  bk = bk + NB;
               end
               fwd = (m == 0) && b_pixph_ff;
            end
            vec_in[j] = fwd ? b_pix_ff : rd_data[bk];
         end
      end
   end

   // which stored column feeds each window column
   always_comb begin
      int c;
      int idx;
      for (int j = 0; j < NB; j++) begin
         c = int'(c_ox_ff) + j - MAX_RADIUS;
         if (c < 0) begin
            c = 0;
         end else if (c > int'(w_ff) - 1) begin
            c = int'(w_ff) - 1;
         end
         idx = int'(c_ox_ff) + int'(r_ff) - c;
         if (idx < 0 || idx > NB - 1) begin
            idx = 0;
         end
         col_idx[j] = BW'(idx);
      end
   end

   // unused slots: low half at zero, high half at full scale
   always_comb begin
      int dy;
      int dx;
      for (int yi = 0; yi < NB; yi++) begin
         for (int xi = 0; xi < NB; xi++) begin
            dy = (yi > MAX_RADIUS) ? yi - MAX_RADIUS : MAX_RADIUS - yi;
            dx = (xi > MAX_RADIUS) ? xi - MAX_RADIUS : MAX_RADIUS - xi;
            if (dy <= int'(r_ff) && dx <= int'(r_ff)) begin
               win_in[yi*NB + xi] = cols_ff[col_idx[xi]][yi];
            end else if (yi*NB + xi < NW / 2) begin
               win_in[yi*NB + xi] = '0;
            end else begin
               win_in[yi*NB + xi] = '1;
            end
         end
      end
   end

   assign c_ctl.valid     = c_valid_ff;
   assign c_ctl.frame_end = c_fe_ff;

   wmf_median #(
      .PIXEL_BITS (PIXEL_BITS),
      .SIDE       (NB)
   ) u_median (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_ctl    (c_ctl),
      .in_win    (win_in),
      .out_ctl   (m_ctl),
      .out_value (m_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= m_ctl.valid;
      end
      if (en) begin
         rsp_median_ff <= PIX_PORT_BITS'(m_value);
         rsp_fe_ff     <= m_ctl.frame_end;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.median_value = rsp_median_ff;
   assign rsp_ch.frame_end    = rsp_fe_ff;
endmodule

@@ sv/wmf_ram.sv @@
// wmf_ram: generic single write port ram with registered read
// no dependencies

module wmf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ sv/wmf_median.sv @@
// wmf_median: rank based median selection over the window, three stages
// depends on wmf_pkg

module wmf_median #(
   parameter int PIXEL_BITS = 16,
   parameter int SIDE       = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  wmf_pkg::ctl_type      in_ctl,
   input  logic [PIXEL_BITS-1:0] in_win [SIDE*SIDE],
   output wmf_pkg::ctl_type      out_ctl,
   output logic [PIXEL_BITS-1:0] out_value
);
   import wmf_pkg::*;

   localparam int NW  = SIDE * SIDE;
   localparam int MID = (NW - 1) / 2;

   ctl_type               ctl1_ff, ctl2_ff, ctl3_ff;
   logic [PIXEL_BITS-1:0] win1_ff [NW];
   logic [PIXEL_BITS-1:0] win2_ff [NW];
   logic [PIXEL_BITS-1:0] win3_ff [NW];
   logic [NW-1:0]         lt_in [NW];
   logic [NW-1:0]         le_in [NW];
   logic [NW-1:0]         lt_ff [NW];
   logic [NW-1:0]         le_ff [NW];
   logic [NW-1:0]         sel_in, sel_ff;

   always_comb begin
      for (int i = 0; i < NW; i++) begin
         for (int j = 0; j < NW; j++) begin
            lt_in[i][j] = win1_ff[j] < win1_ff[i];
            le_in[i][j] = win1_ff[j] <= win1_ff[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NW; i++) begin
         sel_in[i] = ($countones(lt_ff[i]) <= MID) && ($countones(le_ff[i]) > MID);
      end
   end

   always_comb begin
      out_value = '0;
      for (int i = 0; i < NW; i++) begin
         out_value = out_value | (sel_ff[i] ? win3_ff[i] : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else if (en) begin
         ctl1_ff <= in_ctl;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
      end
      if (en) begin
         win1_ff <= in_win;
         win2_ff <= win1_ff;
         win3_ff <= win2_ff;
         lt_ff   <= lt_in;
         le_ff   <= le_in;
         sel_ff  <= sel_in;
      end
   end

   assign out_ctl = ctl3_ff;
endmodule
